// ===== rtl/ilid_pkg.sv =====
package ilid_pkg;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_POS  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         length;
    } t_out_item;

    // memory read address source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_KM1,
        RD_KP1
    } t_rd_sel;

    // memory write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_K_RDATA,
        WR_POS_VAL
    } t_wr_sel;

    typedef enum logic [2:0] {
        K_HOLD,
        K_SET_CNT,
        K_SET_POS,
        K_DEC,
        K_INC
    } t_k_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef struct packed {
        logic    cap;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_k_op   k_op;
        t_cnt_op cnt_op;
        logic    keep_rd;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic pos_lt_cnt;
        logic pos_gt_cnt;
        logic full;
        logic k_gt_pos;
        logic k1_lt_cnt;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/ilid_dp.sv =====
module ilid_dp import ilid_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_k;
    logic [1:0]         r_op;
    logic [6:0]         r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_res_val;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] k_ext;
    logic [CW-1:0]   km1;
    logic [CW:0]     kp1;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic            rd_en;
    logic            wr_en;

    assign pos_ext = CMPW'(r_pos);
    assign cnt_ext = CMPW'(r_count);
    assign k_ext   = CMPW'(r_k);
    assign km1     = r_k - CW'(1);
    assign kp1     = {1'b0, r_k} + (CW + 1)'(1);

    assign o_sts.op         = t_op'(r_op);
    assign o_sts.pos_lt_cnt = pos_ext < cnt_ext;
    assign o_sts.pos_gt_cnt = pos_ext > cnt_ext;
    assign o_sts.full       = r_count == CW'(CAPACITY);
    assign o_sts.k_gt_pos   = k_ext > pos_ext;
    assign o_sts.k1_lt_cnt  = kp1 < {1'b0, r_count};
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = pos_ext[AW-1:0];
        unique case (i_cmd.rd_sel)
            RD_NONE: rd_en   = 1'b0;
            RD_POS:  rd_addr = pos_ext[AW-1:0];
            RD_KM1:  rd_addr = km1[AW-1:0];
            RD_KP1:  rd_addr = kp1[AW-1:0];
            default: rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_k[AW-1:0];
        wr_data = r_rdata;
        unique case (i_cmd.wr_sel)
            WR_NONE:    wr_en = 1'b0;
            WR_K_RDATA: begin
                wr_addr = r_k[AW-1:0];
                wr_data = r_rdata;
            end
            WR_POS_VAL: begin
                wr_addr = pos_ext[AW-1:0];
                wr_data = r_val;
            end
            default:    wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= i_in_item.op;
            r_pos     <= i_in_item.position;
            r_val     <= i_in_item.value;
            r_res_val <= '0;
        end else if (i_cmd.keep_rd) begin
            r_res_val <= r_rdata;
        end
        unique case (i_cmd.k_op)
            K_HOLD:    r_k <= r_k;
            K_SET_CNT: r_k <= r_count;
            K_SET_POS: r_k <= pos_ext[CW-1:0];
            K_DEC:     r_k <= km1;
            K_INC:     r_k <= kp1[CW-1:0];
            default:   r_k <= r_k;
        endcase
        if (i_cmd.out_load) begin
            r_out_item.status     <= i_cmd.out_status;
            r_out_item.read_value <= r_res_val;
            r_out_item.length     <= cnt_ext[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_HOLD: r_count <= r_count;
                CNT_INC:  r_count <= r_count + CW'(1);
                CNT_DEC:  r_count <= r_count - CW'(1);
                CNT_CLR:  r_count <= '0;
                default:  r_count <= r_count;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/ilid_ctrl.sv =====
module ilid_ctrl import ilid_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_CAP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state           = r_state;
        n_status          = r_status;
        o_cmd.cap         = 1'b0;
        o_cmd.rd_sel      = RD_NONE;
        o_cmd.wr_sel      = WR_NONE;
        o_cmd.k_op        = K_HOLD;
        o_cmd.cnt_op      = CNT_HOLD;
        o_cmd.keep_rd     = 1'b0;
        o_cmd.out_load    = 1'b0;
        o_cmd.out_status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_status  = ST_OK;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_GET: begin
                        if (i_sts.pos_lt_cnt) begin
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_GET_CAP;
                        end else begin
                            n_status = ST_POS;
                            n_state  = S_FIN;
                        end
                    end
                    OP_INSERT: begin
                        priority if (i_sts.pos_gt_cnt) begin
                            n_status = ST_POS;
                            n_state  = S_FIN;
                        end else if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.k_op = K_SET_CNT;
                            n_state    = S_INS_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.pos_lt_cnt) begin
                            o_cmd.rd_sel = RD_POS;
                            o_cmd.k_op   = K_SET_POS;
                            n_state      = S_DEL_CAP;
                        end else begin
                            n_status = ST_POS;
                            n_state  = S_FIN;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLR;
                        n_state      = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_GET_CAP: begin
                o_cmd.keep_rd = 1'b1;
                n_state       = S_FIN;
            end
            // move entries up from the tail, then drop the new value in
            S_INS_RD: begin
                if (i_sts.k_gt_pos) begin
                    o_cmd.rd_sel = RD_KM1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_sel = WR_POS_VAL;
                    o_cmd.cnt_op = CNT_INC;
                    n_state      = S_FIN;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_sel = WR_K_RDATA;
                o_cmd.k_op   = K_DEC;
                n_state      = S_INS_RD;
            end
            S_DEL_CAP: begin
                o_cmd.keep_rd = 1'b1;
                n_state       = S_DEL_RD;
            end
            // pull later entries down one place
            S_DEL_RD: begin
                if (i_sts.k1_lt_cnt) begin
                    o_cmd.rd_sel = RD_KP1;
                    n_state      = S_DEL_WR;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_FIN;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_sel = WR_K_RDATA;
                o_cmd.k_op   = K_INC;
                n_state      = S_DEL_RD;
            end
            S_FIN: begin
                // hold until the output register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

// ===== rtl/indexed_list_insert_delete.sv =====
// Channel   Valid        Stall        Payload
// input     i_in_valid   o_in_stall   i_in_item  (op, position, value)
// output    o_out_valid  i_out_stall  o_out_item (status, read_value, length)
//
// Get reads its entry and captures it before finishing; clear and errors go straight from decode to finish.
// Insert and delete move the entries between position and the tail one at a time:
// each moved entry costs one read and one write on the entry memory.
// Reset empties the list at once; the entry memory is not cleared.
// A result waiting under i_out_stall does not block the next accept; a
// finished operation holds until the output register frees.
module indexed_list_insert_delete import ilid_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ilid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ilid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import ilid_pkg::*;

    localparam int LIST_CAP    = 64;
    localparam int N_ITEMS     = 1600;
    localparam int TAIL_CYCLES = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_script_row;

    logic signed [31:0] shadow_list[$];
    t_out_item          pending_results[$];
    t_script_row        script[$];
    int                 mismatches = 0;
    int                 beats_sent = 0;
    int                 burst_left = 0;
    int                 stall_mode = 0;
    int                 stall_left = 0;
    int                 stall_tick = 0;

    indexed_list_insert_delete #(.CAPACITY(LIST_CAP)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one operation to the shadow list and return the result it gives.
    function automatic t_out_item apply_list_op(input t_in_item it);
        t_out_item res;
        int        cnt;
        int        pos;
        cnt = shadow_list.size();
        pos = int'(it.position);
        res = '0;
        res.status = ST_OK;
        case (it.op)
            OP_GET: begin
                if (pos < cnt) begin
                    res.read_value = shadow_list[pos];
                end else begin
                    res.status = ST_POS;
                end
            end
            OP_INSERT: begin
                // position check wins over the full check
                if (pos > cnt) begin
                    res.status = ST_POS;
                end else if (cnt >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else if (pos == cnt) begin
                    shadow_list.push_back(it.value);
                end else begin
                    shadow_list.insert(pos, it.value);
                end
            end
            OP_DELETE: begin
                if (pos < cnt) begin
                    res.read_value = shadow_list[pos];
                    shadow_list.delete(pos);
                end else begin
                    res.status = ST_POS;
                end
            end
            default: begin
                shadow_list.delete();
            end
        endcase
        res.length = 7'(shadow_list.size());
        return res;
    endfunction

    function automatic t_in_item make_item(input t_op op, input int pos,
                                           input logic [31:0] val);
        t_in_item it;
        it.op       = op;
        it.position = 7'(pos);
        it.value    = val;
        return it;
    endfunction

    function automatic t_script_row make_row(input t_op op, input int pos,
                                             input logic [31:0] val, input logic typed,
                                             input t_status st, input logic [31:0] rd,
                                             input int len);
        t_script_row row;
        row.item            = make_item(op, pos, val);
        row.typed           = typed;
        row.want.status     = st;
        row.want.read_value = rd;
        row.want.length     = 7'(len);
        return row;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Favor both ends of the list so shift lengths cover the whole range.
    function automatic int pick_position(input bit for_insert);
        int top;
        top = shadow_list.size() - (for_insert ? 0 : 1);
        if (top < 0) begin
            return $urandom_range(0, 127);
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_beat(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        logic      taken;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        taken = 1'b0;
        // outputs settle by the falling edge; the beat moves on the next rising edge
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end
        predicted = apply_list_op(it);
        pending_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic random_beats();
        int        kind;
        t_out_item none;
        none = '0;
        while (beats_sent < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // grow to capacity, then hit the full list
                while (shadow_list.size() < LIST_CAP) begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_beat(make_item(OP_GET, pick_position(0), pick_value()), 0, none);
                    end else begin
                        push_beat(make_item(OP_INSERT, pick_position(1), pick_value()),
                                  0, none);
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    push_beat(make_item(OP_INSERT, $urandom_range(0, 127), pick_value()),
                              0, none);
                end
            end else if (kind <= 6) begin
                // drain to empty, then poke the empty list
                while (shadow_list.size() > 0) begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_beat(make_item(OP_GET, pick_position(0), pick_value()), 0, none);
                    end else begin
                        push_beat(make_item(OP_DELETE, pick_position(0), pick_value()),
                                  0, none);
                    end
                end
                repeat ($urandom_range(1, 3)) begin
                    push_beat(make_item(t_op'($urandom_range(0, 2)), $urandom_range(0, 127),
                                        pick_value()), 0, none);
                end
            end else if (kind <= 8) begin
                repeat ($urandom_range(20, 60)) begin
                    t_op op;
                    int  pos;
                    op  = t_op'($urandom_range(0, 2));
                    pos = ($urandom_range(0, 19) < 17) ? pick_position(op == OP_INSERT)
                                                       : $urandom_range(0, 127);
                    push_beat(make_item(op, pos, pick_value()), 0, none);
                end
            end else begin
                repeat ($urandom_range(5, 15)) begin
                    push_beat(make_item(t_op'($urandom_range(0, 3)), $urandom_range(0, 127),
                                        $urandom()), 0, none);
                end
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: %h", got));
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          got.status, want.status));
            end
            if (got.read_value !== want.read_value) begin
                report_mismatch($sformatf("read_value %h, predicted %h",
                                          got.read_value, want.read_value));
            end
            if (got.length !== want.length) begin
                report_mismatch($sformatf("length %0d, predicted %0d",
                                          got.length, want.length));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            check_result(o_out_item);
        end
    end

    // Receiver stall: modes of random length - open, light, heavy, periodic.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;

        script.push_back(make_row(OP_GET,    0,   32'h0, 1, ST_POS, 32'h0, 0));
        script.push_back(make_row(OP_DELETE, 0,   32'h0, 1, ST_POS, 32'h0, 0));
        script.push_back(make_row(OP_INSERT, 1,   32'h5, 1, ST_POS, 32'h0, 0));
        script.push_back(make_row(OP_INSERT, 127, 32'h5, 1, ST_POS, 32'h0, 0));
        script.push_back(make_row(OP_INSERT, 0,   32'h8000_0000, 1, ST_OK, 32'h0, 1));
        script.push_back(make_row(OP_INSERT, 64,  32'h1, 1, ST_POS, 32'h0, 1));
        script.push_back(make_row(OP_INSERT, 1,   32'h7FFF_FFFF, 1, ST_OK, 32'h0, 2));
        script.push_back(make_row(OP_INSERT, 0,   32'hFFFF_FFFF, 1, ST_OK, 32'h0, 3));
        script.push_back(make_row(OP_INSERT, 1,   32'h0, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_GET,    3,   32'h0, 1, ST_OK, 32'h7FFF_FFFF, 4));
        script.push_back(make_row(OP_GET,    0,   32'h0, 1, ST_OK, 32'hFFFF_FFFF, 4));
        script.push_back(make_row(OP_GET,    4,   32'h0, 1, ST_POS, 32'h0, 4));
        script.push_back(make_row(OP_GET,    64,  32'h0, 1, ST_POS, 32'h0, 4));
        script.push_back(make_row(OP_DELETE, 4,   32'h0, 1, ST_POS, 32'h0, 4));
        script.push_back(make_row(OP_DELETE, 1,   32'h0, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_DELETE, 0,   32'h0, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_INSERT, 2,   32'h5555_5555, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_DELETE, 2,   32'h0, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_GET,    127, 32'h0, 1, ST_POS, 32'h0, 2));
        script.push_back(make_row(OP_CLEAR,  127, 32'hAAAA_AAAA, 1, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_GET,    0,   32'h0, 1, ST_POS, 32'h0, 0));
        script.push_back(make_row(OP_CLEAR,  0,   32'h0, 1, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_INSERT, 0,   32'hAAAA_AAAA, 0, ST_OK, 32'h0, 0));
        script.push_back(make_row(OP_DELETE, 0,   32'h0, 0, ST_OK, 32'h0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            push_beat(script[k].item, script[k].typed, script[k].want);
        end
        random_beats();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #(8 * 1_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
